FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/clc_pkg.sv
// Types and constants for the comment line counter.
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int OUT_WIDTH  = 32;
   localparam int NUM_CNT    = 4;

   // counter slots
   localparam int CNT_CHAR  = 0;
   localparam int CNT_LINE  = 1;
   localparam int CNT_LCMT  = 2;
   localparam int CNT_BCMT  = 3;

   localparam logic [BYTE_WIDTH-1:0] CH_SLASH   = 8'h2F;
   localparam logic [BYTE_WIDTH-1:0] CH_STAR    = 8'h2A;
   localparam logic [BYTE_WIDTH-1:0] CH_NEWLINE = 8'h0A;

   typedef enum logic [4:0] {
      MODE_TEXT  = 5'b00001,
      MODE_SLASH = 5'b00010,
      MODE_LINE  = 5'b00100,
      MODE_BLOCK = 5'b01000,
      MODE_STAR  = 5'b10000
   } mode_type;

   // counter advance requests for one byte
   typedef struct packed {
      logic bcmt;
      logic lcmt;
      logic line;
      logic chr;
   } bump_type;

endpackage

`default_nettype wire

FILE: hw/rtl/clc_lexer.sv
// Lexer state machine: tracks comment mode, flags which counters advance.
`timescale 1ns / 1ps
`default_nettype none

module clc_lexer
   import clc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [BYTE_WIDTH-1:0] char_byte,
   output bump_type                   bump
);

   mode_type mode_ff;
   mode_type mode_in;
   logic     is_nl;
   logic     is_slash;
   logic     is_star;

   assign is_nl    = (char_byte == CH_NEWLINE);
   assign is_slash = (char_byte == CH_SLASH);
   assign is_star  = (char_byte == CH_STAR);

   always_comb begin
      mode_in   = mode_ff;
      bump.chr  = 1'b1;
      bump.line = is_nl;
      bump.lcmt = 1'b0;
      bump.bcmt = 1'b0;
      case (mode_ff)
         MODE_SLASH: begin
            if (is_slash) begin
               mode_in = MODE_LINE;
            end else if (is_star) begin
               mode_in = MODE_BLOCK;
            end else begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_LINE: begin
            if (is_nl) begin
               bump.lcmt = 1'b1;
               mode_in   = MODE_TEXT;
            end
         end
         MODE_BLOCK: begin
            if (is_star) begin
               mode_in = MODE_STAR;
            end else if (is_nl) begin
               bump.bcmt = 1'b1;
            end
         end
         MODE_STAR: begin
            if (is_slash) begin
               bump.bcmt = 1'b1;
               mode_in   = MODE_TEXT;
            end else if (!is_star) begin
               bump.bcmt = is_nl;
               mode_in   = MODE_BLOCK;
            end
         end
         default: begin
            // text mode and any stray code
            mode_in = is_slash ? MODE_SLASH : MODE_TEXT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
      end else if (advance) begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/clc_counters.sv
// Four saturating counters that also serve as the result register.
`timescale 1ns / 1ps
`default_nettype none

module clc_counters
   import clc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire bump_type             bump,
   output logic [OUT_WIDTH-1:0]      count_out [NUM_CNT]
);

   logic [COUNT_WIDTH-1:0] cnt_ff [NUM_CNT];
   logic [COUNT_WIDTH-1:0] cnt_in [NUM_CNT];
   logic [NUM_CNT-1:0]     bump_vec;

   assign bump_vec[CNT_CHAR] = bump.chr;
   assign bump_vec[CNT_LINE] = bump.line;
   assign bump_vec[CNT_LCMT] = bump.lcmt;
   assign bump_vec[CNT_BCMT] = bump.bcmt;

   for (genvar i = 0; i < NUM_CNT; i++) begin : g_cnt
      // hold at all ones
      always_comb begin
         cnt_in[i] = cnt_ff[i];
         if (bump_vec[i] && (cnt_ff[i] != {COUNT_WIDTH{1'b1}})) begin
            cnt_in[i] = cnt_ff[i] + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else if (advance) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end

      if (COUNT_WIDTH >= OUT_WIDTH) begin : g_trunc
         assign count_out[i] = cnt_ff[i][OUT_WIDTH-1:0];
      end else begin : g_ext
         assign count_out[i] = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, cnt_ff[i]};
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/comment_line_counter.sv
// Top level of the comment line counter.
//
// Counts characters, newlines, line-comment lines and block-comment lines in a
// byte stream, one byte per req transfer. Every accepted byte yields exactly
// one rsp transfer carrying all four counts after that byte is counted.
// A block-comment line counts at each newline inside a block comment and once
// more at the closing star-slash.
//
// req channel: req_tdata[7:0] = char_byte.
// rsp channel: four 32-bit counts packed low to high (see port list).
// Result: rsp_tvalid and the counts are registered, valid in the cycle after the req transfer.
// Throughput: one byte per cycle while rsp_tready is high; the counters are the
// result register, so the next byte is taken in the same cycle the result is taken.
// Stall: while rsp_tvalid is high and rsp_tready is low the result holds and
// req_tready is low; nothing is dropped.
// Reset: synchronous, active high; lexer to text mode, counts to zero, rsp
// channel empty.
// Counters are COUNT_WIDTH bits, saturate at all ones, and are shown as their
// low 32 bits (zero-extended when narrower).
`timescale 1ns / 1ps
`default_nettype none

module comment_line_counter
   import clc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // byte stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] char_byte
   // count stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // [31:0] char_count, [63:32] line_count,
                                          // [95:64] line_comment_count,
                                          // [127:96] block_comment_count
);

   logic                 rsp_tvalid_ff;
   logic                 rsp_tvalid_in;
   logic                 req_xfer;
   bump_type             bump;
   logic [OUT_WIDTH-1:0] count_out [NUM_CNT];

   // accept whenever the result slot is empty or draining this cycle
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (req_xfer) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   clc_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_xfer),
      .char_byte (req_tdata[BYTE_WIDTH-1:0]),
      .bump      (bump)
   );

   clc_counters #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_counters (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_xfer),
      .bump      (bump),
      .count_out (count_out)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {count_out[CNT_BCMT], count_out[CNT_LCMT],
                        count_out[CNT_LINE], count_out[CNT_CHAR]};

endmodule

`default_nettype wire

FILE: hw/rtl/clc_checker.sv
// Port-level checks for the comment line counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clc_checker
   import clc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [7:0]   req_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata
);

   logic req_xfer;
   logic not_nl;

   assign req_xfer = req_tvalid && req_tready;
   assign not_nl   = (req_tdata != CH_NEWLINE);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `ASSERT_NEXT(a_rsp_after_req, clock, reset, req_xfer,
      rsp_tvalid, "no result after accepted byte")
   `ASSERT_NEXT(a_counts_idle, clock, reset, !req_xfer,
      $stable(rsp_tdata), "counts moved without a byte")
   `ASSERT_NEXT(a_line_only_nl, clock, reset, req_xfer && not_nl,
      $stable(rsp_tdata[95:32]), "line counts moved on a non-newline byte")

endmodule

bind comment_line_counter clc_checker u_clc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
